@@ design/bpr_pkg.sv @@
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared types and constants of the two-level branch predictor core.
// ----------------------------------------------------------------------------
package bpr_pkg;

    localparam int ENTRY_LOG2_MAX = 5;
    localparam int NUM_ENTRIES    = 1 << ENTRY_LOG2_MAX;
    localparam int IDX_W          = ENTRY_LOG2_MAX;
    localparam int HIST_MAX       = 8;
    localparam int TAG_MAX        = 30;
    localparam int ROW_CTRS       = 1 << HIST_MAX;
    localparam int ROW_W          = 2 * ROW_CTRS;
    localparam int NUM_ROWS       = NUM_ENTRIES + 1;
    localparam int ROW_AW         = $clog2(NUM_ROWS);
    localparam int DATA_W         = 104;

    localparam logic [2:0] CFG_ENTRIES_LOG2 = 3'd0;
    localparam logic [2:0] CFG_HISTORY_BITS = 3'd1;
    localparam logic [2:0] CFG_TAG_BITS     = 3'd2;
    localparam logic [2:0] CFG_INIT_COUNTER = 3'd3;
    localparam logic [2:0] CFG_HIST_GLOBAL  = 3'd4;
    localparam logic [2:0] CFG_TABLE_GLOBAL = 3'd5;
    localparam logic [2:0] CFG_SHARE_MODE   = 3'd6;

    localparam logic [1:0] SHARE_NONE = 2'd0;
    localparam logic [1:0] SHARE_LOW  = 2'd1;
    localparam logic [1:0] SHARE_HIGH = 2'd2;

    typedef struct packed {
        logic [2:0] entries_log2;
        logic [3:0] history_bits;
        logic [4:0] tag_bits;
        logic [1:0] initial_counter;
        logic       history_is_global;
        logic       table_is_global;
        logic [1:0] share_mode;
    } cfg_t;

    typedef struct packed {
        logic               action;
        logic [31:0]        pc;
        logic [31:0]        target;
        logic               taken;
        logic [31:0]        pdst;
        logic [IDX_W-1:0]   idx;
        logic [TAG_MAX-1:0] tag;
    } req_t;

endpackage

@@ design/bpr_ram.sv @@
// ----------------------------------------------------------------------------
// bpr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ design/bpr_front.sv @@
// ----------------------------------------------------------------------------
// bpr_front
// Configuration registers and request decode: BTB index and tag extraction.
// ----------------------------------------------------------------------------
module bpr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [4:0]          cfg_data,
    input  logic                in_action,
    input  logic [31:0]         in_pc,
    input  logic [31:0]         in_target,
    input  logic                in_taken,
    input  logic [31:0]         in_pdst,
    output bpr_pkg::req_t       req,
    output bpr_pkg::cfg_t       cfg,
    output logic                cfg_clear
);
    import bpr_pkg::*;

    cfg_t         cfg_reg;
    cfg_t         cfg_next;
    logic [2:0]   eff_log2;
    logic [4:0]   eff_tag;
    logic [4:0]   idx_mask;
    logic [29:0]  tag_mask;
    logic [31:0]  pc_shift;

    always_comb
    begin
        cfg_next  = cfg_reg;
        cfg_clear = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENTRIES_LOG2: cfg_next.entries_log2      = cfg_data[2:0];
                CFG_HISTORY_BITS: cfg_next.history_bits      = cfg_data[3:0];
                CFG_TAG_BITS:     cfg_next.tag_bits          = cfg_data;
                CFG_INIT_COUNTER: cfg_next.initial_counter   = cfg_data[1:0];
                CFG_HIST_GLOBAL:  cfg_next.history_is_global = cfg_data[0];
                CFG_TABLE_GLOBAL: cfg_next.table_is_global   = cfg_data[0];
                CFG_SHARE_MODE:   cfg_next.share_mode        = cfg_data[1:0];
                default:          cfg_next = cfg_reg;
            endcase
            cfg_clear = (cfg_index <= CFG_SHARE_MODE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{entries_log2: 3'd5, history_bits: 4'd8, tag_bits: 5'd30,
                         initial_counter: 2'd1, history_is_global: 1'b0,
                         table_is_global: 1'b0, share_mode: SHARE_NONE};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    always_comb
    begin
        eff_log2 = (cfg_reg.entries_log2 > 3'(ENTRY_LOG2_MAX)) ? 3'(ENTRY_LOG2_MAX)
                                                               : cfg_reg.entries_log2;
        eff_tag  = (cfg_reg.tag_bits > 5'(TAG_MAX)) ? 5'(TAG_MAX) : cfg_reg.tag_bits;
        idx_mask = 5'((6'd1 << eff_log2) - 6'd1);
        tag_mask = 30'((31'd1 << eff_tag) - 31'd1);
        pc_shift = in_pc >> (32'd2 + 32'(eff_log2));
        req.action = in_action;
        req.pc     = in_pc;
        req.target = in_target;
        req.taken  = in_taken;
        req.pdst   = in_pdst;
        req.idx    = in_pc[6:2] & idx_mask;
        req.tag    = pc_shift[29:0] & tag_mask;
    end
endmodule

@@ design/bpr_queue.sv @@
// ----------------------------------------------------------------------------
// bpr_queue
// Two-entry request queue between the decode front and the execute back.
// ----------------------------------------------------------------------------
module bpr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bpr_pkg::req_t push_item,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output bpr_pkg::req_t item
);
    import bpr_pkg::*;

    req_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign item    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

@@ design/bpr_back.sv @@
// ----------------------------------------------------------------------------
// bpr_back
// Execute stage: BTB lookup, counter row read-modify-write, totals, output.
// ----------------------------------------------------------------------------
module bpr_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bpr_pkg::cfg_t               cfg,
    input  logic                        cfg_clear,
    input  logic                        q_valid,
    input  bpr_pkg::req_t               q_item,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bpr_pkg::DATA_W-1:0]  m_tdata
);
    import bpr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [NUM_ENTRIES-1:0] btb_valid_reg;
    logic [TAG_MAX-1:0]    btb_tag_reg    [NUM_ENTRIES];
    logic [31:0]           btb_target_reg [NUM_ENTRIES];
    logic [HIST_MAX-1:0]   btb_hist_reg   [NUM_ENTRIES];
    logic [HIST_MAX-1:0]   ghist_reg;
    logic [NUM_ROWS-1:0]   row_valid_reg;
    req_t                  cur_reg;
    logic                  hit_reg;
    logic                  fresh_reg;
    logic [HIST_MAX-1:0]   col_reg;
    logic [HIST_MAX-1:0]   old_hist_reg;
    logic [ROW_AW-1:0]     row_reg;
    logic                  out_valid_reg;
    logic [DATA_W-1:0]     out_data_reg;
    logic [31:0]           pred_cnt_reg;
    logic [31:0]           flush_cnt_reg;

    logic [3:0]            eff_hist;
    logic [HIST_MAX-1:0]   hmask;
    logic                  lk_hit;
    logic [HIST_MAX-1:0]   lk_hist;
    logic [HIST_MAX-1:0]   lk_src;
    logic [HIST_MAX-1:0]   lk_share;
    logic [HIST_MAX-1:0]   lk_col;
    logic [ROW_AW-1:0]     lk_row;
    logic                  lk_fresh;
    logic                  start;
    logic                  finish;
    logic [ROW_W-1:0]      row_data;
    logic [ROW_W-1:0]      row_new;
    logic [1:0]            ctr;
    logic [1:0]            ctr_new;
    logic                  res_taken;
    logic [31:0]           res_dest;
    logic                  res_flush;
    logic [31:0]           pc_plus4;
    logic [31:0]           actual;
    logic [31:0]           pred_cnt_next;
    logic [31:0]           flush_cnt_next;
    logic [HIST_MAX-1:0]   hist_new_local;
    logic [HIST_MAX-1:0]   hist_new_global;
    logic                  ram_we;
    logic [ROW_W-1:0]      ram_rdata;

    always_comb
    begin
        eff_hist = (cfg.history_bits > 4'(HIST_MAX)) ? 4'(HIST_MAX) : cfg.history_bits;
        hmask    = HIST_MAX'((9'd1 << eff_hist) - 9'd1);
        lk_hit   = btb_valid_reg[q_item.idx] && (btb_tag_reg[q_item.idx] == q_item.tag);
        lk_hist  = lk_hit ? btb_hist_reg[q_item.idx] : '0;
        lk_src   = cfg.history_is_global ? ghist_reg : lk_hist;
        lk_share = '0;
        if (cfg.table_is_global)
        begin
            priority if (cfg.share_mode == SHARE_LOW)
                lk_share = q_item.pc[2 +: HIST_MAX];
            else if (cfg.share_mode == SHARE_HIGH)
                lk_share = q_item.pc[16 +: HIST_MAX];
            else
                lk_share = '0;
        end
        lk_col   = (lk_src ^ lk_share) & hmask;
        lk_row   = cfg.table_is_global ? ROW_AW'(NUM_ENTRIES) : ROW_AW'(q_item.idx);
        lk_fresh = !row_valid_reg[lk_row]
                   || (q_item.action && !lk_hit && !cfg.table_is_global);
    end

    assign start  = (state_reg == ST_IDLE) && q_valid;
    assign finish = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);
    assign q_pop  = start;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start)  state_next = ST_EXEC;
            ST_EXEC: if (finish) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        row_data  = fresh_reg ? {ROW_CTRS{cfg.initial_counter}} : ram_rdata;
        ctr       = row_data[{col_reg, 1'b0} +: 2];
        ctr_new   = cur_reg.taken ? ((ctr == 2'd3) ? ctr : ctr + 2'd1)
                                  : ((ctr == 2'd0) ? ctr : ctr - 2'd1);
        row_new   = row_data;
        row_new[{col_reg, 1'b0} +: 2] = ctr_new;
        pc_plus4  = cur_reg.pc + 32'd4;
        actual    = cur_reg.taken ? cur_reg.target : pc_plus4;
        res_taken = 1'b0;
        res_dest  = '0;
        res_flush = 1'b0;
        pred_cnt_next  = pred_cnt_reg;
        flush_cnt_next = flush_cnt_reg;
        if (!cur_reg.action)
        begin
            res_taken = hit_reg && ctr[1];
            res_dest  = res_taken ? btb_target_reg[cur_reg.idx] : pc_plus4;
            if (pred_cnt_reg != 32'hFFFF_FFFF)
                pred_cnt_next = pred_cnt_reg + 32'd1;
        end
        else
        begin
            res_flush = (actual != cur_reg.pdst);
            if (res_flush && flush_cnt_reg != 32'hFFFF_FFFF)
                flush_cnt_next = flush_cnt_reg + 32'd1;
        end
        hist_new_local  = {old_hist_reg[HIST_MAX-2:0], cur_reg.taken} & hmask;
        hist_new_global = {ghist_reg[HIST_MAX-2:0], cur_reg.taken} & hmask;
        ram_we = finish && cur_reg.action;
    end

    bpr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_ROWS)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (row_reg),
        .wdata (row_new),
        .re    (start),
        .raddr (lk_row),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            btb_valid_reg <= '0;
            row_valid_reg <= '0;
            ghist_reg     <= '0;
            out_valid_reg <= 1'b0;
            pred_cnt_reg  <= '0;
            flush_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                pred_cnt_reg  <= pred_cnt_next;
                flush_cnt_reg <= flush_cnt_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_clear)
            begin
                btb_valid_reg <= '0;
                row_valid_reg <= '0;
                ghist_reg     <= '0;
            end
            else if (finish && cur_reg.action)
            begin
                btb_valid_reg[cur_reg.idx] <= 1'b1;
                row_valid_reg[row_reg]     <= 1'b1;
                if (cfg.history_is_global)
                    ghist_reg <= hist_new_global;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_reg      <= q_item;
            hit_reg      <= lk_hit;
            fresh_reg    <= lk_fresh;
            col_reg      <= lk_col;
            old_hist_reg <= lk_hist;
            row_reg      <= lk_row;
        end
        if (finish)
        begin
            out_data_reg <= {6'd0, flush_cnt_next, pred_cnt_next, res_flush, res_dest,
                             res_taken};
            if (cur_reg.action)
            begin
                btb_tag_reg[cur_reg.idx]    <= cur_reg.tag;
                btb_target_reg[cur_reg.idx] <= cur_reg.target;
                btb_hist_reg[cur_reg.idx]   <= hist_new_local;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule

@@ design/btb_two_level_branch_predictor_core.sv @@
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor_core
// Direct-mapped BTB with two-level two-bit counter prediction and totals.
// ----------------------------------------------------------------------------
// In the execute stage each request first looks up the BTB and reads the
// counter row from the counter RAM, then picks the counter, writes the trained
// row back on an update and loads the result register. The counter RAM
// holds one 512-bit row per BTB entry plus one row for the shared table, so
// allocation and configuration clear rows through per-row valid flags with no
// clearing pass. A two-entry queue in front of the execute stage keeps
// s_tready high for up to two further requests while a result waits on
// m_tready.
module btb_two_level_branch_predictor_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [4:0]                 cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // pc[31:0], resolved_target[63:32], resolved_taken[64], predicted_dest[96:65]
    input  logic [bpr_pkg::DATA_W-1:0] s_tdata,
    // action
    input  logic                       s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // predict_taken[0], predict_dest[32:1], was_flush[33],
    // prediction_total[65:34], flush_total[97:66]
    output logic [bpr_pkg::DATA_W-1:0] m_tdata
);
    import bpr_pkg::*;

    req_t dec_req;
    req_t q_item;
    cfg_t cfg;
    logic cfg_clear;
    logic q_full;
    logic q_valid;
    logic q_pop;

    bpr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_action (s_tuser),
        .in_pc     (s_tdata[31:0]),
        .in_target (s_tdata[63:32]),
        .in_taken  (s_tdata[64]),
        .in_pdst   (s_tdata[96:65]),
        .req       (dec_req),
        .cfg       (cfg),
        .cfg_clear (cfg_clear)
    );

    bpr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_item (dec_req),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .item      (q_item)
    );

    assign s_tready = !q_full;

    bpr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_clear (cfg_clear),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );
endmodule

@@ test/btb_two_level_branch_predictor_core_tb.sv @@
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor_core_tb
// Self-checking bench for the BTB predictor core: a predictor of its own works
// out each result, and random gaps, long receiver hold-offs and register
// sweeps exercise the lookup, allocation, training and totals.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor_core_tb;
    import bpr_pkg::*;

    typedef struct {
        logic        taken;
        logic [31:0] dest;
        logic        flush;
        logic [31:0] pred_total;
        logic [31:0] flush_total;
    } result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [2:0]          cfg_index;
    logic [4:0]          cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [DATA_W-1:0]   m_tdata;

    btb_two_level_branch_predictor_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // predictor state
    logic [2:0]  r_entries;
    logic [3:0]  r_hist;
    logic [4:0]  r_tag;
    logic [1:0]  r_init;
    logic        r_hglob;
    logic        r_tglob;
    logic [1:0]  r_share;
    logic        btb_valid  [NUM_ENTRIES];
    logic [31:0] btb_tag    [NUM_ENTRIES];
    logic [31:0] btb_target [NUM_ENTRIES];
    logic [7:0]  btb_hist   [NUM_ENTRIES];
    logic [7:0]  ghist;
    logic [1:0]  gctr       [ROW_CTRS];
    logic [1:0]  ectr       [NUM_ENTRIES][ROW_CTRS];
    logic [31:0] pred_count;
    logic [31:0] flush_count;

    result_t     expected_results[$];
    int          mismatches;
    int          results_seen;
    int          requests_sent;
    int          hold_cycles;
    bit          stall_mode;
    bit          quiet_rx;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int eff_entries();
        return (r_entries > 3'd5) ? 5 : int'(r_entries);
    endfunction

    function automatic int eff_hist();
        return (r_hist > 4'd8) ? 8 : int'(r_hist);
    endfunction

    function automatic int eff_tag();
        return (r_tag > 5'd30) ? 30 : int'(r_tag);
    endfunction

    function automatic logic [31:0] bits_of(logic [31:0] v, int len, int sh);
        logic [31:0] m;
        m = (len >= 32) ? 32'hFFFF_FFFF : ((32'd1 << len) - 32'd1);
        return (v >> sh) & m;
    endfunction

    function automatic void clear_state();
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            btb_valid[i]  = 1'b0;
            btb_tag[i]    = '0;
            btb_target[i] = '0;
            btb_hist[i]   = '0;
            for (int j = 0; j < ROW_CTRS; j++)
                ectr[i][j] = r_init;
        end
        for (int j = 0; j < ROW_CTRS; j++)
            gctr[j] = r_init;
        ghist = '0;
    endfunction

    function automatic int counter_slot(logic [31:0] pc, int idx);
        int          h;
        logic [31:0] src;
        h   = eff_hist();
        src = r_hglob ? 32'(ghist) : 32'(btb_hist[idx]);
        if (r_tglob)
        begin
            if (r_share == SHARE_LOW)
                src = src ^ bits_of(pc, h, 2);
            else if (r_share == SHARE_HIGH)
                src = src ^ bits_of(pc, h, 16);
        end
        return int'(src & ((32'd1 << h) - 32'd1));
    endfunction

    function automatic logic [1:0] read_ctr(int idx, int slot);
        return r_tglob ? gctr[slot] : ectr[idx][slot];
    endfunction

    function automatic void write_ctr(int idx, int slot, logic [1:0] v);
        if (r_tglob)
            gctr[slot] = v;
        else
            ectr[idx][slot] = v;
    endfunction

    function automatic result_t predict_branch(logic action, logic [31:0] pc,
                                               logic [31:0] tgt, logic taken,
                                               logic [31:0] pdst);
        result_t     r;
        int          e;
        int          idx;
        int          slot;
        logic [31:0] tg;
        logic [31:0] actual;
        logic [1:0]  c;
        logic        hit;
        logic [7:0]  hmask;
        e     = eff_entries();
        idx   = int'(bits_of(pc, e, 2));
        tg    = bits_of(pc, eff_tag(), 2 + e);
        hit   = btb_valid[idx] && (btb_tag[idx] == tg);
        hmask = 8'((32'd1 << eff_hist()) - 32'd1);
        r.taken = 1'b0;
        r.dest  = '0;
        r.flush = 1'b0;
        if (action == 1'b0)
        begin
            if (pred_count != 32'hFFFF_FFFF)
                pred_count++;
            r.dest = pc + 32'd4;
            if (hit && read_ctr(idx, counter_slot(pc, idx)) >= 2'd2)
            begin
                r.taken = 1'b1;
                r.dest  = btb_target[idx];
            end
        end
        else
        begin
            actual = taken ? tgt : pc + 32'd4;
            if (actual != pdst)
            begin
                r.flush = 1'b1;
                if (flush_count != 32'hFFFF_FFFF)
                    flush_count++;
            end
            if (!hit)
            begin
                btb_valid[idx] = 1'b1;
                btb_tag[idx]   = tg;
                btb_hist[idx]  = '0;
                if (!r_tglob)
                    for (int j = 0; j < ROW_CTRS; j++)
                        ectr[idx][j] = r_init;
            end
            slot = counter_slot(pc, idx);
            c    = read_ctr(idx, slot);
            if (taken && c != 2'd3)
                c++;
            else if (!taken && c != 2'd0)
                c--;
            write_ctr(idx, slot, c);
            if (r_hglob)
                ghist = ((ghist << 1) | 8'(taken)) & hmask;
            else
                btb_hist[idx] = ((btb_hist[idx] << 1) | 8'(taken)) & hmask;
            btb_target[idx] = tgt;
        end
        r.pred_total  = pred_count;
        r.flush_total = flush_count;
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [4:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            CFG_ENTRIES_LOG2: r_entries = value[2:0];
            CFG_HISTORY_BITS: r_hist    = value[3:0];
            CFG_TAG_BITS:     r_tag     = value;
            CFG_INIT_COUNTER: r_init    = value[1:0];
            CFG_HIST_GLOBAL:  r_hglob   = value[0];
            CFG_TABLE_GLOBAL: r_tglob   = value[0];
            CFG_SHARE_MODE:   r_share   = value[1:0];
            default: ;
        endcase
        clear_state();
    endtask

    task automatic set_all(logic [2:0] e, logic [3:0] h, logic [4:0] t, logic [1:0] i,
                           logic hg, logic tg, logic [1:0] s);
        wait_drained();
        write_reg(CFG_ENTRIES_LOG2, 5'(e));
        write_reg(CFG_HISTORY_BITS, 5'(h));
        write_reg(CFG_TAG_BITS, t);
        write_reg(CFG_INIT_COUNTER, 5'(i));
        write_reg(CFG_HIST_GLOBAL, 5'(hg));
        write_reg(CFG_TABLE_GLOBAL, 5'(tg));
        write_reg(CFG_SHARE_MODE, 5'(s));
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(logic action, logic [31:0] pc, logic [31:0] tgt,
                                logic taken, logic [31:0] pdst, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {7'd0, pdst, taken, tgt, pc};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(predict_branch(action, pc, tgt, taken, pdst));
        requests_sent++;
    endtask

    // a resolved branch; the predicted destination is right most of the time
    task automatic send_branch(logic [31:0] pc, logic [31:0] tgt, logic taken, bit gaps);
        logic [31:0] pd;
        pd = taken ? tgt : pc + 32'd4;
        if ($urandom_range(0, 3) == 0)
            pd = $urandom();
        send_request(1'b1, pc, tgt, taken, pd, gaps);
    endtask

    // checker
    always @(posedge clk)
    begin
        result_t     exp_r;
        result_t     got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.taken       = m_tdata[0];
            got.dest        = m_tdata[32:1];
            got.flush       = m_tdata[33];
            got.pred_total  = m_tdata[65:34];
            got.flush_total = m_tdata[97:66];
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.taken !== exp_r.taken || got.dest !== exp_r.dest ||
                    got.flush !== exp_r.flush || got.pred_total !== exp_r.pred_total ||
                    got.flush_total !== exp_r.flush_total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp t=%b d=%h f=%b p=%0d fl=%0d got t=%b d=%h f=%b p=%0d fl=%0d",
                                 exp_r.taken, exp_r.dest, exp_r.flush, exp_r.pred_total,
                                 exp_r.flush_total, got.taken, got.dest, got.flush,
                                 got.pred_total, got.flush_total);
                end
            end
        end
    end

    // receiver ready
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_tready <= 1'b0;
        end
        else if (quiet_rx)
            m_tready <= 1'b1;
        else if (stall_mode)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                m_tready    <= 1'b0;
                hold_cycles = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                            : $urandom_range(0, 2);
            end
            else
                m_tready <= 1'b1;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic test_directed();
        logic [31:0] pc;
        pc = 32'h0000_1000;
        send_request(1'b0, pc, '0, 1'b0, '0, 1'b0);
        send_branch(pc, 32'h0000_2000, 1'b1, 1'b0);
        send_branch(pc, 32'h0000_2000, 1'b1, 1'b0);
        send_request(1'b0, pc, '0, 1'b0, '0, 1'b0);
        send_request(1'b1, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0);
        send_request(1'b0, 32'hFFFF_FFFC, '0, 1'b0, '0, 1'b0);
        send_request(1'b1, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0);
        send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
        send_request(1'b1, 32'h0, 32'hAAAA_5555, 1'b1, 32'hAAAA_5555, 1'b0);
        send_request(1'b0, 32'h0, '0, 1'b0, '0, 1'b0);
        // aliasing pc with a different tag evicts
        send_branch(32'h0000_0080, 32'h1234_5678, 1'b1, 1'b0);
        send_request(1'b0, 32'h0, '0, 1'b0, '0, 1'b0);
        // oversized settings saturate; share mode three acts as none
        set_all(3'd7, 4'd15, 5'd31, 2'd3, 1'b1, 1'b1, 2'd3);
        send_branch(32'h0000_4444, 32'h0000_8888, 1'b1, 1'b0);
        send_request(1'b0, 32'h0000_4444, '0, 1'b0, '0, 1'b0);
        // one entry, zero history, no tag
        set_all(3'd0, 4'd0, 5'd0, 2'd2, 1'b0, 1'b0, SHARE_NONE);
        send_request(1'b0, 32'h0000_0010, '0, 1'b0, '0, 1'b0);
        send_branch(32'h0000_0010, 32'h0000_0100, 1'b0, 1'b0);
        send_request(1'b0, 32'hDEAD_BEEF, '0, 1'b0, '0, 1'b0);
        send_branch(32'hDEAD_BEEF, 32'h0000_0100, 1'b1, 1'b0);
        send_request(1'b0, 32'h0000_0010, '0, 1'b0, '0, 1'b0);
    endtask

    task automatic random_phase(int n);
        logic [31:0] pcs[8];
        logic [31:0] tgts[8];
        int          k;
        for (int i = 0; i < 8; i++)
        begin
            pcs[i]  = $urandom();
            tgts[i] = $urandom();
        end
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 7);
            case ($urandom_range(0, 9))
                0: send_request($urandom_range(0, 1), $urandom(), $urandom(),
                                $urandom_range(0, 1), $urandom(), 1'b1);
                1, 2, 3, 4: send_request(1'b0, pcs[k], $urandom(), $urandom_range(0, 1),
                                         $urandom(), 1'b1);
                default: send_branch(pcs[k], ($urandom_range(0, 7) == 0) ? $urandom()
                                     : tgts[k], ($urandom_range(0, 3) != 0), 1'b1);
            endcase
        end
    endtask

    task automatic test_random_configs();
        for (int p = 0; p < 12; p++)
        begin
            set_all($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 31),
                    $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1),
                    $urandom_range(0, 3));
            random_phase(60);
        end
        set_all(3'd5, 4'd8, 5'd30, 2'd0, 1'b1, 1'b1, SHARE_HIGH);
        random_phase(60);
        set_all(3'd5, 4'd1, 5'd30, 2'd3, 1'b1, 1'b1, SHARE_LOW);
        random_phase(60);
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 60;
        for (int i = 0; i < 12; i++)
            send_request(1'b0, $urandom(), '0, 1'b0, '0, 1'b0);
        wait_drained();
        quiet_rx = 1'b1;
        random_phase(50);
        quiet_rx = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        requests_sent = 0;
        hold_cycles   = 0;
        stall_mode    = 1'b0;
        quiet_rx      = 1'b0;
        r_entries = 3'd5;
        r_hist    = 4'd8;
        r_tag     = 5'd30;
        r_init    = 2'd1;
        r_hglob   = 1'b0;
        r_tglob   = 1'b0;
        r_share   = SHARE_NONE;
        pred_count  = '0;
        flush_count = '0;
        clear_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        stall_mode = 1'b1;
        test_random_configs();
        test_backpressure();
        wait_drained();
        repeat (20) @(posedge clk);
        $display("covered %0d requests and %0d results over register sweeps,",
                 requests_sent, results_seen);
        $display("eviction, saturated settings and receiver hold-offs");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ sim.f @@
design/bpr_pkg.sv
design/bpr_ram.sv
design/bpr_front.sv
design/bpr_queue.sv
design/bpr_back.sv
design/btb_two_level_branch_predictor_core.sv
test/btb_two_level_branch_predictor_core_tb.sv
